>>> sv/srit_pkg.sv
// ----------------------------------------------------------------------------
// srit_pkg: shared types and constants for the sorted reminder table
// Field widths, command and status codes, controller states, and the
// minute-of-day key function.
// ----------------------------------------------------------------------------
package srit_pkg;

    localparam int DayW  = 5;
    localparam int HourW = 5;
    localparam int MinW  = 6;
    localparam int TagW  = 16;
    localparam int KeyW  = 11;   // hour*60 + minute stays below 2048

    // Longest dump read-out, in entries
    localparam int MaxOut = 32;

    localparam logic [KeyW-1:0] MinPerHour = 11'd60;
    localparam logic [DayW-1:0] NoDay      = '0;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DUMP   = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_DAY = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_DUMP
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [DayW-1:0]   day;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [TagW-1:0]   tag;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [DayW-1:0]   out_day;
        logic [HourW-1:0]  out_hour;
        logic [MinW-1:0]   out_minute;
        logic [TagW-1:0]   out_tag;
        logic              last;
    } t_rsp;

    // One stored entry; key kept alongside so cells need no multiplier
    typedef struct packed {
        logic [DayW-1:0]   day;
        logic [HourW-1:0]  hour;
        logic [MinW-1:0]   minute;
        logic [TagW-1:0]   tag;
        logic [KeyW-1:0]   key;
    } t_entry;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // insert: shift down from the take point, load new entry
        logic rot;   // rotate: move one place towards the head, head wraps to tail
    } t_cell_ctl;

    // Where a cell sits relative to the current fill count
    typedef struct packed {
        logic occupied;   // index below count
        logic at_count;   // index equals count (first free slot)
        logic at_tail;    // index equals count - 1
    } t_cell_pos;

    function automatic logic [KeyW-1:0] key_of(input logic [HourW-1:0] hour,
                                               input logic [MinW-1:0]  minute);
        key_of = KeyW'(hour) * MinPerHour + KeyW'(minute);
    endfunction

endpackage

>>> sv/srit_req_if.sv
// ----------------------------------------------------------------------------
// srit_req_if: command channel of the sorted reminder table
// valid/ready handshake carrying one insert or dump command.
// ----------------------------------------------------------------------------
interface srit_req_if
    import srit_pkg::*;
    ;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/srit_rsp_if.sv
// ----------------------------------------------------------------------------
// srit_rsp_if: result channel of the sorted reminder table
// valid/ready handshake carrying one status or read-out entry.
// ----------------------------------------------------------------------------
interface srit_rsp_if
    import srit_pkg::*;
    ;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/sorted_reminder_insert_table.sv
// ----------------------------------------------------------------------------
// sorted_reminder_insert_table: reminder table kept sorted by (day, minute)
// Insert: the accepted command is first latched with its key; then, in
//   S_INSERT, one parallel compare-and-shift runs across the cell chain as
//   the result register loads. Ready returns on that same edge, so a new
//   command waits for the result to load. An untaken result holds it off.
// Dump: one entry per cycle from the head cell while the result side keeps
//   up, with the whole chain rotated once so the table ends in its original
//   order. Only the first MaxOut are emitted; an empty table answers ST_EMPTY.
// Reset: synchronous, active low; clears the fill count, the controller and
//   the result valid flag only. The entry cells hold no reset and are
//   ignored beyond the count.
// ----------------------------------------------------------------------------
module sorted_reminder_insert_table
    import srit_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    srit_req_if.sink        i_req,
    srit_rsp_if.source      o_rsp
);

    localparam int CntW = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [CntW-1:0]   r_count, n_count;   // stored entries
    logic [CntW-1:0]   r_step,  n_step;    // dump rotation index
    t_entry            r_new;              // latched command entry, key precomputed

    // Result register
    t_rsp              r_rsp, n_rsp;
    logic              r_rsp_valid;
    logic              w_load;

    // Chain wiring
    t_cell_ctl         w_ctl;
    t_entry            w_entry [DEPTH];
    logic              w_take  [DEPTH];

    logic              w_accept;
    logic              w_out_free;
    logic              w_emit;       // this rotation step produces a result
    logic              w_last;       // final result of the dump
    logic              w_step_go;    // a rotation step happens this cycle
    logic              w_step_end;   // last rotation step

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_rsp_valid || o_rsp.ready;

    // Only the first MaxOut entries are read out; the rest rotate silently
    assign w_emit     = int'(r_step) < MaxOut;
    assign w_last     = (r_step == r_count - CntW'(1)) || (int'(r_step) == MaxOut - 1);
    assign w_step_go  = (r_count != '0) && (!w_emit || w_out_free);
    assign w_step_end = (r_step == r_count - CntW'(1));

    // ------------------------------------------------------------------
    // Command latch; the key multiply is registered here
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new.day    <= i_req.data.day;
            r_new.hour   <= i_req.data.hour;
            r_new.minute <= i_req.data.minute;
            r_new.tag    <= i_req.data.tag;
            r_new.key    <= key_of(i_req.data.hour, i_req.data.minute);
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req.data.cmd == CMD_DUMP) ? S_DUMP : S_INSERT;
                end
            end
            S_INSERT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP: begin
                if (r_count == '0) begin
                    if (w_out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (w_step_go && w_step_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs: chain command, result, count and step updates
    // ------------------------------------------------------------------
    always_comb begin
        w_ctl   = '0;
        w_load  = 1'b0;
        n_count = r_count;
        n_step  = r_step;
        n_rsp   = '0;
        n_rsp.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
            end
            S_INSERT: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    n_rsp.last = 1'b1;
                    // Full check ahead of the day check
                    if (r_count == CntW'(DEPTH)) begin
                        n_rsp.status = ST_FULL;
                    end else if (r_new.day == NoDay) begin
                        n_rsp.status = ST_BAD_DAY;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CntW'(1);
                    end
                end
            end
            S_DUMP: begin
                if (r_count == '0) begin
                    w_load       = w_out_free;
                    n_rsp.status = ST_EMPTY;
                    n_rsp.last   = 1'b1;
                end else if (w_step_go) begin
                    w_ctl.rot        = 1'b1;
                    w_load           = w_emit;
                    n_rsp.out_day    = w_entry[0].day;
                    n_rsp.out_hour   = w_entry[0].hour;
                    n_rsp.out_minute = w_entry[0].minute;
                    n_rsp.out_tag    = w_entry[0].tag;
                    n_rsp.last       = w_last;
                    n_step           = w_step_end ? '0 : r_step + CntW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
        end
    end

    // ------------------------------------------------------------------
    // Result register: holds one transaction until the sink takes it
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_load) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 is the head (earliest entry). Insert shifts every
    // cell after the take point down by one; rotate moves entries towards
    // the head with the head wrapping into the tail cell.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_pos w_pos;
        t_entry    w_prev;
        t_entry    w_next;
        logic      w_prev_take;

        assign w_pos.occupied = CntW'(g) < r_count;
        assign w_pos.at_count = CntW'(g) == r_count;
        assign w_pos.at_tail  = CntW'(g) == r_count - CntW'(1);

        if (g == 0) begin : g_head
            assign w_prev      = r_new;
            assign w_prev_take = 1'b0;
        end else begin : g_body
            assign w_prev      = w_entry[g-1];
            assign w_prev_take = w_take[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_next = w_entry[0];
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end

        srit_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_pos       (w_pos),
            .i_prev_take (w_prev_take),
            .i_new       (r_new),
            .i_prev      (w_prev),
            .i_next      (w_next),
            .i_head      (w_entry[0]),
            .o_entry     (w_entry[g]),
            .o_take      (w_take[g])
        );
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("fill count above table depth");

    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ((r_count == $past(r_count) + CntW'(1)) && ($past(r_state) == S_INSERT)))
        else $error("fill count changed outside an insert");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DUMP) && (r_count != '0)) |-> (r_step < r_count))
        else $error("dump step past the fill count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_rsp_valid || o_rsp.ready))
        else $error("result register loaded while holding an untaken result");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("controller idle right after taking a command");

endmodule

>>> sv/srit_cell.sv
// ----------------------------------------------------------------------------
// srit_cell: one slot of the sorted entry chain
// Holds one entry, flags whether the new entry belongs at or before it, and
// loads from its neighbours on insert (shift down) or rotate (shift up).
// ----------------------------------------------------------------------------
module srit_cell
    import srit_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_cell_pos i_pos,
    input  logic      i_prev_take,
    input  t_entry    i_new,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    input  t_entry    i_head,
    output t_entry    o_entry,
    output logic      o_take
);

    t_entry r_entry;
    t_entry n_entry;

    // Equal (day, key) takes too: the new entry goes ahead of equal ones
    assign o_take = (i_pos.occupied &&
                     {r_entry.day, r_entry.key} >= {i_new.day, i_new.key}) ||
                    i_pos.at_count;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_prev_take) begin
                n_entry = i_prev;
            end else if (o_take) begin
                n_entry = i_new;
            end
        end else if (i_ctl.rot) begin
            n_entry = i_pos.at_tail ? i_head : i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
